// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros shared by the frame parser modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising aclk edge outside reset.
`define PSFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define PSFP_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// ----- hdl/psfp_pkg.sv -----
// ----------------------------------------------------------------------------
// psfp_pkg
// Constants and types shared by the particle sensor frame parser.
// ----------------------------------------------------------------------------
package psfp_pkg;

    localparam int FRAME_BYTES = 32;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int WORD_COUNT  = 12;
    localparam int IDX_W       = 4;
    localparam int WORD_W      = 16;

    localparam logic [7:0] START_A = 8'h42;
    localparam logic [7:0] START_B = 8'h4D;

    localparam logic [POS_W-1:0] FIRST_WORD_POS = POS_W'(4);
    localparam logic [POS_W-1:0] WORD_END_POS   = POS_W'(4 + 2 * WORD_COUNT);
    localparam logic [POS_W-1:0] CHECK_HI_POS   = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] LAST_POS       = POS_W'(FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0] LAST_IDX       = IDX_W'(WORD_COUNT - 1);

    typedef struct packed {
        logic              en;
        logic              bsel;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] data;
    } psfp_wr_t;

    typedef struct packed {
        logic bad;
        logic bsel;
    } psfp_cmd_t;

    typedef struct packed {
        logic en;
        logic bsel;
    } psfp_rel_t;

endpackage

// ----- hdl/psfp_queue.sv -----
// ----------------------------------------------------------------------------
// psfp_queue
// Two-entry command queue between the frame front end and the result drain.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psfp_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  psfp_pkg::psfp_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                q_valid,
    output psfp_pkg::psfp_cmd_t q_cmd
);
    import psfp_pkg::*;

    psfp_cmd_t   entry_reg [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = entry_reg[rptr_reg];

    always_comb begin
        wptr_next  = push ? ~wptr_reg : wptr_reg;
        rptr_next  = pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

    `PSFP_NEVER(a_no_overflow, push && full && !pop, "command queue overflow")
    `PSFP_NEVER(a_no_underflow, pop && !q_valid, "command queue underflow")
    `PSFP_NEVER(a_count_range, count_reg == 2'd3, "command queue count out of range")

endmodule

// ----- hdl/psfp_front.sv -----
// ----------------------------------------------------------------------------
// psfp_front
// Hunt for the start pair, collect the frame, store words, check the sum.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psfp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] rx_byte
    output psfp_pkg::psfp_wr_t  wr,
    output logic                push,
    output psfp_pkg::psfp_cmd_t push_cmd,
    input  logic                q_full,
    input  psfp_pkg::psfp_rel_t rel
);
    import psfp_pkg::*;

    localparam logic [1:0] PH_SEEK    = 2'd0;
    localparam logic [1:0] PH_GOT42   = 2'd1;
    localparam logic [1:0] PH_COLLECT = 2'd2;

    logic [1:0]        phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [WORD_W-1:0] sum_reg, sum_next;
    logic [7:0]        chk_hi_reg, chk_hi_next;
    logic [7:0]        hold_reg, hold_next;
    logic              wr_sel_reg, wr_sel_next;
    logic [1:0]        busy_reg, busy_next;

    logic [7:0]        b;
    logic              accept;
    logic              in_words;
    logic              word_pos;
    logic              end_pos;
    logic [POS_W-1:0]  rel_pos;
    logic              good;

    assign b        = s_tdata;
    assign in_words = (pos_reg >= FIRST_WORD_POS) && (pos_reg < WORD_END_POS);
    assign word_pos = in_words && pos_reg[0];
    assign end_pos  = (pos_reg == LAST_POS);
    assign rel_pos  = pos_reg - FIRST_WORD_POS;
    assign good     = ({chk_hi_reg, b} == sum_reg);

    assign s_tready = !((phase_reg == PH_COLLECT) &&
                        ((word_pos && busy_reg[wr_sel_reg]) || (end_pos && q_full)));
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        chk_hi_next  = chk_hi_reg;
        hold_next    = hold_reg;
        wr_sel_next  = wr_sel_reg;
        busy_next    = busy_reg;
        wr.en        = 1'b0;
        wr.bsel      = wr_sel_reg;
        wr.idx       = rel_pos[IDX_W:1];
        wr.data      = {hold_reg, b};
        push         = 1'b0;
        push_cmd.bad = !good;
        push_cmd.bsel = wr_sel_reg;

        if (rel.en) begin
            busy_next[rel.bsel] = 1'b0;
        end

        if (accept) begin
            unique case (phase_reg)
                PH_GOT42: begin
                    if (b == START_B) begin
                        phase_next = PH_COLLECT;
                        pos_next   = POS_W'(2);
                        sum_next   = WORD_W'(START_A) + WORD_W'(START_B);
                    end else if (b == START_A) begin
                        phase_next = PH_GOT42;
                    end else begin
                        phase_next = PH_SEEK;
                        pos_next   = '0;
                    end
                end
                PH_COLLECT: begin
                    if (pos_reg < CHECK_HI_POS) begin
                        sum_next = sum_reg + WORD_W'(b);
                    end
                    if (in_words && !pos_reg[0]) begin
                        hold_next = b;
                    end
                    if (word_pos) begin
                        wr.en = 1'b1;
                    end
                    if (pos_reg == CHECK_HI_POS) begin
                        chk_hi_next = b;
                    end
                    if (end_pos) begin
                        push       = 1'b1;
                        phase_next = PH_SEEK;
                        pos_next   = '0;
                        if (good) begin
                            busy_next[wr_sel_reg] = 1'b1;
                            wr_sel_next           = ~wr_sel_reg;
                        end
                    end else begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
                default: begin
                    phase_next = (b == START_A) ? PH_GOT42 : PH_SEEK;
                    pos_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SEEK;
            pos_reg    <= '0;
            sum_reg    <= '0;
            chk_hi_reg <= '0;
            hold_reg   <= '0;
            wr_sel_reg <= 1'b0;
            busy_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            chk_hi_reg <= chk_hi_next;
            hold_reg   <= hold_next;
            wr_sel_reg <= wr_sel_next;
            busy_reg   <= busy_next;
        end
    end

    `PSFP_NEVER(a_no_write_busy, wr.en && busy_reg[wr.bsel], "word written into draining buffer")

endmodule

// ----- hdl/psfp_back.sv -----
// ----------------------------------------------------------------------------
// psfp_back
// Drain queued frame commands into the result output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psfp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  psfp_pkg::psfp_cmd_t           q_cmd,
    output logic                          pop,
    output logic                          rd_bsel,
    output logic [psfp_pkg::IDX_W-1:0]    rd_idx,
    input  logic [psfp_pkg::WORD_W-1:0]   rd_data,
    output psfp_pkg::psfp_rel_t           rel,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,  // [3:0] word_index, [19:4] word_value
    output logic                          m_tuser,  // [0] status
    output logic                          m_tlast
);
    import psfp_pkg::*;

    logic              m_valid_reg, m_valid_next;
    logic              m_status_reg, m_status_next;
    logic [IDX_W-1:0]  m_index_reg, m_index_next;
    logic [WORD_W-1:0] m_value_reg, m_value_next;
    logic              m_last_reg, m_last_next;
    logic              active_reg, active_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              buf_reg, buf_next;
    logic              load;

    assign load    = !m_valid_reg || m_tready;
    assign rd_bsel = active_reg ? buf_reg : q_cmd.bsel;
    assign rd_idx  = active_reg ? idx_reg : '0;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_value_reg, m_index_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_index_next  = m_index_reg;
        m_value_next  = m_value_reg;
        m_last_next   = m_last_reg;
        active_next   = active_reg;
        idx_next      = idx_reg;
        buf_next      = buf_reg;
        pop           = 1'b0;
        rel.en        = 1'b0;
        rel.bsel      = buf_reg;

        if (load) begin
            priority if (active_reg) begin
                m_valid_next  = 1'b1;
                m_status_next = 1'b0;
                m_index_next  = idx_reg;
                m_value_next  = rd_data;
                m_last_next   = (idx_reg == LAST_IDX);
                if (idx_reg == LAST_IDX) begin
                    active_next = 1'b0;
                    rel.en      = 1'b1;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end else if (q_valid) begin
                pop          = 1'b1;
                m_valid_next = 1'b1;
                m_index_next = '0;
                if (q_cmd.bad) begin
                    m_status_next = 1'b1;
                    m_value_next  = '0;
                    m_last_next   = 1'b1;
                end else begin
                    m_status_next = 1'b0;
                    m_value_next  = rd_data;
                    m_last_next   = 1'b0;
                    active_next   = 1'b1;
                    idx_next      = IDX_W'(1);
                    buf_next      = q_cmd.bsel;
                end
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            active_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            active_reg  <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_index_reg  <= m_index_next;
        m_value_reg  <= m_value_next;
        m_last_reg   <= m_last_next;
        idx_reg      <= idx_next;
        buf_reg      <= buf_next;
    end

    `PSFP_ASSERT(a_err_is_last, m_valid_reg && m_status_reg |-> m_last_reg, "error result not last")

endmodule

// ----- hdl/particle_sensor_frame_parser.sv -----
// ----------------------------------------------------------------------------
// particle_sensor_frame_parser
// Serial frame parser: start-pair hunt, 32-byte frame, checksum, word output.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while s_tready is high; results leave at one word
//   per cycle while m_tready is high. The last frame byte's command is queued, and
//   then the first result is loaded; a good frame yields its 12 words back to back.
// Two word buffers and a two-entry command queue set the input stall points.
// Reset: synchronous, active low; clears hunt state, queue and output valid.
module particle_sensor_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] word_index, [19:4] word_value
    output logic        m_tuser,   // [0] status
    output logic        m_tlast
);
    import psfp_pkg::*;

    psfp_wr_t          wr;
    psfp_cmd_t         push_cmd;
    psfp_cmd_t         q_cmd;
    psfp_rel_t         rel;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_valid;
    logic              rd_bsel;
    logic [IDX_W-1:0]  rd_idx;
    logic [WORD_W-1:0] rd_data;
    logic [WORD_W-1:0] words_reg [2][WORD_COUNT];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            words_reg[wr.bsel][wr.idx] <= wr.data;
        end
    end

    assign rd_data = words_reg[rd_bsel][rd_idx];

    psfp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .wr       (wr),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full),
        .rel      (rel)
    );

    psfp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    psfp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop),
        .rd_bsel  (rd_bsel),
        .rd_idx   (rd_idx),
        .rd_data  (rd_data),
        .rel      (rel),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the particle sensor frame parser. Sends clean
// frames, start-pair hunts, checksum failures and random byte traffic with
// idle cycles on both streams. A local frame parser predicts every result
// word, and each word from the block is compared against it.
// ----------------------------------------------------------------------------
module tb;
    import psfp_pkg::*;

    localparam int RUN_LIMIT   = 200000;
    localparam int IDLE_PCT    = 28;
    localparam int RANDOM_BYTES = 24;

    typedef enum logic [1:0] {
        SEEK_START_A,
        SEEK_START_B,
        COLLECT_FRAME,
        PHASE_SPARE
    } hunt_t;

    typedef struct {
        logic              status;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] value;
        logic              last;
    } sensor_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    hunt_t             hunt      = SEEK_START_A;
    logic [4:0]        frame_pos = '0;
    logic [15:0]       frame_sum = '0;
    logic [7:0]        check_hi  = '0;
    logic [7:0]        high_hold = '0;
    logic [WORD_W-1:0] meas_words [WORD_COUNT];

    sensor_word_t      pending_words [$];
    logic [WORD_W-1:0] load_words [WORD_COUNT];
    bit                calm        = 1'b0;
    int                fail_count  = 0;
    int                bytes_sent  = 0;
    int                cycle_count = 0;

    particle_sensor_frame_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void parse_byte(logic [7:0] b);
        int unsigned  k;
        logic [15:0]  frame_check;
        sensor_word_t w;
        case (hunt)
            SEEK_START_B: begin
                if (b == START_B) begin
                    hunt      = COLLECT_FRAME;
                    frame_pos = 5'd2;
                    frame_sum = 16'(START_A) + 16'(START_B);
                end else if (b == START_A) begin
                    hunt = SEEK_START_B;
                end else begin
                    hunt      = SEEK_START_A;
                    frame_pos = '0;
                end
            end
            COLLECT_FRAME: begin
                if (frame_pos < FRAME_BYTES - 2)
                    frame_sum = frame_sum + 16'(b);
                if (frame_pos >= 4 && frame_pos < 4 + 2 * WORD_COUNT) begin
                    if (frame_pos[0] == 1'b0) begin
                        high_hold = b;
                    end else begin
                        k = (32'(frame_pos) - 4) >> 1;
                        meas_words[k] = {high_hold, b};
                    end
                end
                if (frame_pos == FRAME_BYTES - 2)
                    check_hi = b;
                if (frame_pos >= FRAME_BYTES - 1) begin
                    frame_check = {check_hi, b};
                    hunt        = SEEK_START_A;
                    frame_pos   = '0;
                    if (frame_check == frame_sum) begin
                        for (k = 0; k < WORD_COUNT; k++) begin
                            w.status = 1'b0;
                            w.idx    = IDX_W'(k);
                            w.value  = meas_words[k];
                            w.last   = (k == WORD_COUNT - 1);
                            pending_words.push_back(w);
                        end
                    end else begin
                        w.status = 1'b1;
                        w.idx    = '0;
                        w.value  = '0;
                        w.last   = 1'b1;
                        pending_words.push_back(w);
                    end
                end else begin
                    frame_pos = frame_pos + 5'd1;
                end
            end
            default: begin
                hunt      = (b == START_A) ? SEEK_START_B : SEEK_START_A;
                frame_pos = '0;
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        sensor_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word idx %0d value %h status %b last %b", $time,
                         m_tdata[3:0], m_tdata[19:4], m_tuser, m_tlast);
                fail_count++;
            end else begin
                w = pending_words.pop_front();
                if (m_tuser !== w.status) begin
                    $display("%0t: status expected %b got %b", $time, w.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata[3:0] !== w.idx) begin
                    $display("%0t: word_index expected %0d got %0d", $time, w.idx,
                             m_tdata[3:0]);
                    fail_count++;
                end
                if (m_tdata[19:4] !== w.value) begin
                    $display("%0t: word_value expected %h got %h", $time, w.value,
                             m_tdata[19:4]);
                    fail_count++;
                end
                if (m_tlast !== w.last) begin
                    $display("%0t: last expected %b got %b", $time, w.last, m_tlast);
                    fail_count++;
                end
            end
        end
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        parse_byte(b);
        bytes_sent++;
    endtask

    // flip = 0 gives a valid checksum
    task automatic send_frame(input logic [15:0] flip);
        logic [7:0]  fb [FRAME_BYTES];
        logic [15:0] sum;
        fb[0] = START_A;
        fb[1] = START_B;
        fb[2] = 8'($urandom);
        fb[3] = 8'($urandom);
        for (int i = 0; i < WORD_COUNT; i++) begin
            fb[4 + 2 * i] = load_words[i][15:8];
            fb[5 + 2 * i] = load_words[i][7:0];
        end
        sum = '0;
        for (int i = 0; i < FRAME_BYTES - 2; i++)
            sum = sum + 16'(fb[i]);
        sum = sum ^ flip;
        fb[FRAME_BYTES - 2] = sum[15:8];
        fb[FRAME_BYTES - 1] = sum[7:0];
        for (int i = 0; i < FRAME_BYTES; i++)
            send_byte(fb[i]);
    endtask

    task automatic fill_words(input logic [15:0] value);
        for (int i = 0; i < WORD_COUNT; i++)
            load_words[i] = value;
    endtask

    task automatic fill_random_words();
        int unsigned roll;
        for (int i = 0; i < WORD_COUNT; i++) begin
            roll = $urandom_range(7);
            load_words[i] = (roll == 0) ? 16'h0000 :
                            (roll == 1) ? 16'hFFFF : 16'($urandom);
        end
    endtask

    task automatic hold_until_drained();
        while (pending_words.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_extreme_frames();
        fill_words(16'hFFFF);
        send_frame(16'h0000);
        // start bytes as plain data inside a frame
        fill_words(16'h0000);
        load_words[3] = {START_A, START_A};
        load_words[7] = {START_A, START_B};
        send_frame(16'h0000);
    endtask

    task automatic test_start_hunt();
        send_byte(START_B);
        send_byte(START_A);
        send_byte(8'h00);
        send_byte(START_A);
        send_byte(8'hFF);
        send_byte(START_A);
        send_byte(START_A);
        fill_random_words();
        send_frame(16'h0000);
    endtask

    task automatic test_bad_checksum();
        fill_random_words();
        send_frame(16'h0001);
    endtask

    task automatic test_steady_stream();
        calm = 1'b1;
        for (int n = 0; n < 2; n++) begin
            fill_random_words();
            send_frame((n == 1) ? 16'h8000 : 16'h0000);
        end
        calm = 1'b0;
    endtask

    task automatic test_drain_between();
        s_tvalid <= 1'b0;
        hold_until_drained();
        fill_random_words();
        send_frame(16'h0000);
    endtask

    task automatic test_random_traffic();
        int unsigned roll;
        int          stop_at;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 60) begin
                fill_random_words();
                send_frame(16'h0000);
            end else if (roll < 75) begin
                fill_random_words();
                send_frame(16'($urandom_range(65535, 1)));
            end else if (roll < 90) begin
                repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
            end else begin
                repeat ($urandom_range(2, 1)) send_byte(START_A);
                send_byte(8'($urandom_range(255, 78)));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extreme_frames();
        test_start_hunt();
        test_bad_checksum();
        test_steady_stream();
        test_drain_between();
        test_random_traffic();
        s_tvalid <= 1'b0;
        hold_until_drained();
        repeat (32) @(posedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/psfp_pkg.sv
hdl/psfp_queue.sv
hdl/psfp_front.sv
hdl/psfp_back.sv
hdl/particle_sensor_frame_parser.sv
tb/tb.sv
